// File: design/tk_pkg.sv
`default_nettype none

package tk_pkg;

    // token kinds
    localparam logic [5:0] K_LPAREN = 6'd0;
    localparam logic [5:0] K_RPAREN = 6'd1;
    localparam logic [5:0] K_LBRACE = 6'd2;
    localparam logic [5:0] K_RBRACE = 6'd3;
    localparam logic [5:0] K_PLUS   = 6'd4;
    localparam logic [5:0] K_MINUS  = 6'd5;
    localparam logic [5:0] K_SEMI   = 6'd6;
    localparam logic [5:0] K_COMMA  = 6'd7;
    localparam logic [5:0] K_DOT    = 6'd8;
    localparam logic [5:0] K_SLASH  = 6'd9;
    localparam logic [5:0] K_STAR   = 6'd10;
    localparam logic [5:0] K_ASSIGN = 6'd11;
    localparam logic [5:0] K_BANG   = 6'd13;
    localparam logic [5:0] K_LESS   = 6'd15;
    localparam logic [5:0] K_MORE   = 6'd17;
    localparam logic [5:0] K_STR    = 6'd19;
    localparam logic [5:0] K_INT    = 6'd20;
    localparam logic [5:0] K_ID     = 6'd21;
    localparam logic [5:0] K_KW0    = 6'd22;
    localparam logic [5:0] K_EOF    = 6'd33;
    localparam logic [5:0] K_ERR    = 6'd34;

    // error kinds
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNTERM  = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN = 2'd2;

    // characters with a meaning of their own
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [23:0] POS_MAX = 24'hFFFFFF;

    localparam int KW_NUM = 11;
    localparam int KW_MAX = 6;
    localparam int Q_DEPTH = 4;

    localparam logic [7:0] KW_CHARS [KW_NUM][KW_MAX] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "l", "a", "s", "s", 8'h00},
        '{"d", "e", "f", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n"},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"v", "a", "l", 8'h00, 8'h00, 8'h00},
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00},
        '{"n", "o", "n", "e", 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{
        3'd2, 3'd5, 3'd3, 3'd6, 3'd4, 3'd4, 3'd5, 3'd5, 3'd3, 3'd3, 3'd4
    };

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_OP,
        MODE_STR,
        MODE_NUM,
        MODE_IDENT,
        MODE_DONE
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [23:0] start;
        logic [15:0] len;
    } t_tok;

    // one queue entry: all tokens caused by one byte
    typedef struct packed {
        t_tok        tok0;
        t_tok        tok1;
        logic        two;
        logic        ident;
        logic [23:0] line;
    } t_entry;

    function automatic t_tok mk_tok(logic [5:0] kind, logic [1:0] err,
                                    logic [23:0] start, logic [15:0] len);
        t_tok t;
        t.kind  = kind;
        t.err   = err;
        t.start = start;
        t.len   = len;
        return t;
    endfunction

    function automatic logic [7:0] kw_char(int k, int i);
        if (i < KW_MAX) begin
            return KW_CHARS[k][i];
        end
        return 8'h00;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_ident_char(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c inside {" ", [8'h09:8'h0D]};
    endfunction

    function automatic logic is_single(logic [7:0] c);
        return c inside {"(", ")", "{", "}", "+", "-", ";", ",", ".", "/", "*"};
    endfunction

    function automatic logic [5:0] single_kind(logic [7:0] c);
        logic [5:0] k;
        case (c)
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            "+": k = K_PLUS;
            "-": k = K_MINUS;
            ";": k = K_SEMI;
            ",": k = K_COMMA;
            ".": k = K_DOT;
            "/": k = K_SLASH;
            "*": k = K_STAR;
            default: k = K_ERR;
        endcase
        return k;
    endfunction

    function automatic logic is_op(logic [7:0] c);
        return c inside {"=", "!", "<", ">"};
    endfunction

    function automatic logic [5:0] op_base(logic [7:0] c);
        logic [5:0] k;
        case (c)
            "=": k = K_ASSIGN;
            "!": k = K_BANG;
            "<": k = K_LESS;
            ">": k = K_MORE;
            default: k = K_ERR;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: design/tk_if.sv
`default_nettype none

interface tk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_input;

    modport source(output valid, output char_byte, output end_of_input, input ready);
    modport sink(input valid, input char_byte, input end_of_input, output ready);
endinterface

interface tk_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [1:0]  error_kind;
    logic [23:0] token_start;
    logic [15:0] token_length;
    logic [23:0] line_number;
    logic        last_of_item;

    modport source(output valid, output token_kind, output error_kind, output token_start,
                   output token_length, output line_number, output last_of_item,
                   input ready);
    modport sink(input valid, input token_kind, input error_kind, input token_start,
                 input token_length, input line_number, input last_of_item,
                 output ready);
endinterface

`default_nettype wire

// File: design/tk_queue.sv
`default_nettype none

module tk_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: design/tk_front.sv
`default_nettype none

module tk_front
    import tk_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = 65535,
    parameter int KEYWORD_BYTES    = 6
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    tk_in_if.sink                                i_in,
    input  wire logic                            i_full,
    output logic                                 o_push,
    output t_entry                               o_entry,
    output logic [KEYWORD_BYTES-1:0][7:0]        o_prefix
);

    localparam logic [15:0] SPAN_CAP =
        (MAX_TOKEN_LENGTH < 65535) ? 16'(MAX_TOKEN_LENGTH) : 16'hFFFF;

    t_mode                          r_mode, n_mode;
    logic [7:0]                     r_op, n_op;
    logic [23:0]                    r_start, n_start;
    logic [15:0]                    r_span, n_span;
    logic [23:0]                    r_line, n_line;
    logic [23:0]                    r_pos, n_pos;
    logic [KEYWORD_BYTES-1:0][7:0]  r_prefix, n_prefix;

    logic        accept;
    logic [7:0]  c;
    logic        is_end;
    logic [15:0] span_p1;
    logic        have0;
    logic        consumed;
    logic        new_vld;
    t_tok        tok0, tok1, new_tok;
    logic        two;
    logic        ident;

    assign c          = i_in.char_byte;
    assign is_end     = i_in.end_of_input || (c == CH_NUL);
    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign span_p1    = (r_span < SPAN_CAP) ? r_span + 16'd1 : r_span;

    always_comb begin
        n_mode   = r_mode;
        n_op     = r_op;
        n_start  = r_start;
        n_span   = r_span;
        n_line   = r_line;
        n_pos    = r_pos;
        n_prefix = r_prefix;
        tok0     = '0;
        tok1     = '0;
        new_tok  = '0;
        two      = 1'b0;
        ident    = 1'b0;
        have0    = 1'b0;
        consumed = 1'b0;
        new_vld  = 1'b0;

        if (r_mode != MODE_DONE) begin
            if (is_end) begin
                // flush the open token, then end-of-file
                case (r_mode)
                    MODE_OP: begin
                        have0 = 1'b1;
                        tok0  = mk_tok(op_base(r_op), ERR_NONE, r_start, 16'd1);
                    end
                    MODE_STR: begin
                        have0 = 1'b1;
                        tok0  = mk_tok(K_ERR, ERR_UNTERM, r_start, r_span);
                    end
                    MODE_NUM: begin
                        have0 = 1'b1;
                        tok0  = mk_tok(K_INT, ERR_NONE, r_start, r_span);
                    end
                    MODE_IDENT: begin
                        have0 = 1'b1;
                        ident = 1'b1;
                        tok0  = mk_tok(K_ID, ERR_NONE, r_start, r_span);
                    end
                    default: ;
                endcase
                if (have0) begin
                    tok1 = mk_tok(K_EOF, ERR_NONE, r_pos, 16'd0);
                    two  = 1'b1;
                end else begin
                    tok0  = mk_tok(K_EOF, ERR_NONE, r_pos, 16'd0);
                    have0 = 1'b1;
                end
                n_mode = MODE_DONE;
            end else begin
                case (r_mode)
                    MODE_OP: begin
                        have0 = 1'b1;
                        if (c == CH_EQ) begin
                            tok0     = mk_tok(op_base(r_op) + 6'd1, ERR_NONE, r_start, 16'd2);
                            consumed = 1'b1;
                        end else begin
                            tok0 = mk_tok(op_base(r_op), ERR_NONE, r_start, 16'd1);
                        end
                        n_mode = MODE_IDLE;
                    end
                    MODE_STR: begin
                        n_span   = span_p1;
                        consumed = 1'b1;
                        if (c == CH_QUOTE) begin
                            have0  = 1'b1;
                            tok0   = mk_tok(K_STR, ERR_NONE, r_start, span_p1);
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_NUM: begin
                        if (is_digit(c)) begin
                            n_span   = span_p1;
                            consumed = 1'b1;
                        end else begin
                            have0  = 1'b1;
                            tok0   = mk_tok(K_INT, ERR_NONE, r_start, r_span);
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_IDENT: begin
                        if (is_ident_char(c)) begin
                            for (int i = 0; i < KEYWORD_BYTES; i++) begin
                                if (r_span == 16'(i)) begin
                                    n_prefix[i] = c;
                                end
                            end
                            n_span   = span_p1;
                            consumed = 1'b1;
                        end else begin
                            have0  = 1'b1;
                            ident  = 1'b1;
                            tok0   = mk_tok(K_ID, ERR_NONE, r_start, r_span);
                            n_mode = MODE_IDLE;
                        end
                    end
                    default: ;
                endcase

                // a byte not taken by the open token starts a new one unless it is blank
                if (!consumed) begin
                    n_mode = MODE_IDLE;
                    if (is_space(c)) begin
                        if (c == CH_NL && r_line < POS_MAX) begin
                            n_line = r_line + 24'd1;
                        end
                    end else if (is_single(c)) begin
                        new_vld = 1'b1;
                        new_tok = mk_tok(single_kind(c), ERR_NONE, r_pos, 16'd1);
                    end else if (is_op(c)) begin
                        n_mode  = MODE_OP;
                        n_op    = c;
                        n_start = r_pos;
                        n_span  = 16'd1;
                    end else if (c == CH_QUOTE) begin
                        n_mode  = MODE_STR;
                        n_start = r_pos;
                        n_span  = 16'd1;
                    end else if (is_digit(c)) begin
                        n_mode  = MODE_NUM;
                        n_start = r_pos;
                        n_span  = 16'd1;
                    end else if (is_alpha(c) || c == CH_UNDER) begin
                        n_mode      = MODE_IDENT;
                        n_start     = r_pos;
                        n_span      = 16'd1;
                        n_prefix    = '0;
                        n_prefix[0] = c;
                    end else begin
                        new_vld = 1'b1;
                        new_tok = mk_tok(K_ERR, ERR_UNKNOWN, r_pos, 16'd1);
                    end
                    if (new_vld) begin
                        if (have0) begin
                            tok1 = new_tok;
                            two  = 1'b1;
                        end else begin
                            tok0  = new_tok;
                            have0 = 1'b1;
                        end
                    end
                end

                if (r_pos < POS_MAX) begin
                    n_pos = r_pos + 24'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_op     <= '0;
            r_start  <= '0;
            r_span   <= '0;
            r_line   <= 24'd1;
            r_pos    <= '0;
            r_prefix <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_op     <= n_op;
            r_start  <= n_start;
            r_span   <= n_span;
            r_line   <= n_line;
            r_pos    <= n_pos;
            r_prefix <= n_prefix;
        end
    end

    assign o_push        = accept && have0;
    assign o_entry.tok0  = tok0;
    assign o_entry.tok1  = tok1;
    assign o_entry.two   = two;
    assign o_entry.ident = ident;
    assign o_entry.line  = r_line;
    assign o_prefix      = r_prefix;

endmodule

`default_nettype wire

// File: design/tk_back.sv
`default_nettype none

module tk_back
    import tk_pkg::*;
#(
    parameter int KEYWORD_BYTES = 6
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire t_entry                            i_entry,
    input  wire logic [KEYWORD_BYTES-1:0][7:0]     i_prefix,
    input  wire logic                              i_empty,
    output logic                                   o_pop,
    tk_out_if.source                               o_out
);

    logic        r_vld;
    t_tok        r_tok;
    logic [23:0] r_line;
    logic        r_last;
    logic        r_sec_vld;
    t_tok        r_sec;

    logic        load;
    logic [5:0]  kind0;
    logic        hit;
    t_tok        head;

    // resolve identifiers against the keyword list
    always_comb begin
        kind0 = i_entry.tok0.kind;
        hit   = 1'b0;
        if (i_entry.ident) begin
            for (int k = KW_NUM - 1; k >= 0; k--) begin
                hit = (i_entry.tok0.len == {13'd0, KW_LEN[k]});
                for (int i = 0; i < KEYWORD_BYTES; i++) begin
                    hit = hit && (i_prefix[i] == kw_char(k, i));
                end
                if (hit) begin
                    kind0 = K_KW0 + 6'(k);
                end
            end
        end
        head      = i_entry.tok0;
        head.kind = kind0;
    end

    assign load  = !r_vld || o_out.ready;
    assign o_pop = load && !r_sec_vld && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_sec_vld <= 1'b0;
        end else if (load) begin
            if (r_sec_vld) begin
                // second token of the same byte; line stays
                r_vld     <= 1'b1;
                r_tok     <= r_sec;
                r_last    <= 1'b1;
                r_sec_vld <= 1'b0;
            end else if (!i_empty) begin
                r_vld      <= 1'b1;
                r_tok      <= head;
                r_line     <= i_entry.line;
                r_last     <= !i_entry.two;
                r_sec_vld  <= i_entry.two;
                r_sec      <= i_entry.tok1;
            end else begin
                r_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_vld;
    assign o_out.token_kind   = r_tok.kind;
    assign o_out.error_kind   = r_tok.err;
    assign o_out.token_start  = r_tok.start;
    assign o_out.token_length = r_tok.len;
    assign o_out.line_number  = r_line;
    assign o_out.last_of_item = r_last;

endmodule

`default_nettype wire

// File: design/source_code_tokenizer_core.sv
`default_nettype none

// Streaming source tokenizer. Takes one source byte per transaction and returns tokens
// (kind, start offset, length, line) on the output channel, zero to two per byte; a
// zero byte or end_of_input flushes the open token and emits end-of-file, after which
// bytes are dropped until reset. The front end classifies one byte per cycle and
// writes all tokens it causes as one entry into a 4-entry queue; the back end resolves
// keywords and sends one token per cycle while the output is ready, from a registered
// output stage. Input sustains one byte per cycle while the queue has room; a byte
// yielding two tokens holds the output for each in turn, so the output port sets the
// long-run rate. A byte's tokens are queued, then loaded into the output register.
module source_code_tokenizer_core
    import tk_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = 65535,
    parameter int KEYWORD_BYTES    = 6
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tk_in_if.sink     i_in,
    tk_out_if.source  o_out
);

    localparam int ENTRY_W = $bits(t_entry) + 8 * KEYWORD_BYTES;

    logic                          push;
    logic                          pop;
    logic                          full;
    logic                          empty;
    t_entry                        wr_entry;
    t_entry                        rd_entry;
    logic [KEYWORD_BYTES-1:0][7:0] wr_prefix;
    logic [KEYWORD_BYTES-1:0][7:0] rd_prefix;
    logic [ENTRY_W-1:0]            rd_data;

    tk_front #(
        .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH),
        .KEYWORD_BYTES   (KEYWORD_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (wr_entry),
        .o_prefix(wr_prefix)
    );

    tk_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(Q_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({wr_prefix, wr_entry}),
        .i_pop  (pop),
        .o_data (rd_data),
        .o_full (full),
        .o_empty(empty)
    );

    assign rd_entry  = rd_data[$bits(t_entry)-1:0];
    assign rd_prefix = rd_data[ENTRY_W-1:$bits(t_entry)];

    tk_back #(
        .KEYWORD_BYTES(KEYWORD_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (rd_entry),
        .i_prefix(rd_prefix),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_source_code_tokenizer_core.sv
`timescale 1ns / 100ps

module tb_source_code_tokenizer_core;
    import tk_pkg::*;

    localparam int          TOK_LEN_MAX = 65535;
    localparam int          KW_BYTES    = 6;
    localparam logic [15:0] SPAN_CAP    = (TOK_LEN_MAX < 65535) ? 16'(TOK_LEN_MAX) : 16'hFFFF;
    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          RANDOM_ITEMS = 1800;
    localparam int          LONG_HOLD   = 400;

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [23:0] start;
        logic [15:0] len;
        logic [23:0] line;
        logic        last;
    } t_token;

    class token_scoreboard;
        t_token      expected_tokens[$];
        string       kw_words[KW_NUM];
        t_mode       mode;
        logic [7:0]  op_char;
        logic [23:0] tok_start;
        logic [15:0] tok_len;
        logic [23:0] line;
        logic [23:0] pos;
        logic [7:0]  kw_buf[KW_BYTES];
        bit          done;
        int          errors;

        function new();
            kw_words = '{"if", "class", "def", "return", "else", "true",
                         "false", "while", "val", "var", "none"};
            mode      = MODE_IDLE;
            op_char   = 8'h00;
            tok_start = '0;
            tok_len   = '0;
            line      = 24'd1;
            pos       = '0;
            kw_buf    = '{default: 8'h00};
            done      = 1'b0;
            errors    = 0;
        endfunction

        function bit is_dec(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_word(logic [7:0] c);
            return is_letter(c) || is_dec(c) || c == CH_UNDER;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == " " || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function bit single_op(logic [7:0] c, output logic [5:0] k);
            k = K_ERR;
            case (c)
                "(": k = K_LPAREN;
                ")": k = K_RPAREN;
                "{": k = K_LBRACE;
                "}": k = K_RBRACE;
                "+": k = K_PLUS;
                "-": k = K_MINUS;
                ";": k = K_SEMI;
                ",": k = K_COMMA;
                ".": k = K_DOT;
                "/": k = K_SLASH;
                "*": k = K_STAR;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function logic [5:0] op_kind(logic [7:0] c);
            case (c)
                "=":     return K_ASSIGN;
                "!":     return K_BANG;
                "<":     return K_LESS;
                default: return K_MORE;
            endcase
        endfunction

        // exact match only: length and every stored byte
        function logic [5:0] word_kind();
            bit hit;
            for (int k = 0; k < KW_NUM; k++) begin
                if (tok_len == kw_words[k].len()) begin
                    hit = 1'b1;
                    for (int i = 0; i < kw_words[k].len(); i++) begin
                        if (kw_buf[i] != kw_words[k][i]) hit = 1'b0;
                    end
                    if (hit) return 6'(K_KW0 + k);
                end
            end
            return K_ID;
        endfunction

        function void emit(logic [5:0] kind, logic [1:0] err, logic [23:0] start,
                           logic [15:0] len);
            expected_tokens.push_back(t_token'{kind, err, start, len, line, 1'b0});
        endfunction

        function void bump_len();
            if (tok_len != SPAN_CAP) tok_len++;
        endfunction

        function void start_token(logic [7:0] c, logic [23:0] here);
            logic [5:0] k;
            mode = MODE_IDLE;
            if (is_blank(c)) begin
                if (c == CH_NL && line != POS_MAX) line++;
            end else if (single_op(c, k)) begin
                emit(k, ERR_NONE, here, 16'd1);
            end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
                mode      = MODE_OP;
                op_char   = c;
                tok_start = here;
                tok_len   = 16'd1;
            end else if (c == CH_QUOTE) begin
                mode      = MODE_STR;
                tok_start = here;
                tok_len   = 16'd1;
            end else if (is_dec(c)) begin
                mode      = MODE_NUM;
                tok_start = here;
                tok_len   = 16'd1;
            end else if (is_letter(c) || c == CH_UNDER) begin
                mode      = MODE_IDENT;
                tok_start = here;
                tok_len   = 16'd1;
                kw_buf    = '{default: 8'h00};
                kw_buf[0] = c;
            end else begin
                emit(K_ERR, ERR_UNKNOWN, here, 16'd1);
            end
        endfunction

        function void scan_byte(logic [7:0] c, logic eoi);
            int          prior_count;
            logic [23:0] here;
            bit          taken;
            t_token      t;
            if (done) return;
            prior_count = expected_tokens.size();
            here        = pos;
            taken       = 1'b0;
            if (eoi || c == CH_NUL) begin
                case (mode)
                    MODE_OP:    emit(op_kind(op_char), ERR_NONE, tok_start, 16'd1);
                    MODE_STR:   emit(K_ERR, ERR_UNTERM, tok_start, tok_len);
                    MODE_NUM:   emit(K_INT, ERR_NONE, tok_start, tok_len);
                    MODE_IDENT: emit(word_kind(), ERR_NONE, tok_start, tok_len);
                    default: ;
                endcase
                emit(K_EOF, ERR_NONE, here, 16'd0);
                mode = MODE_DONE;
                done = 1'b1;
            end else begin
                case (mode)
                    MODE_OP: begin
                        // the '=' form is coded one above the bare operator
                        if (c == CH_EQ) begin
                            emit(op_kind(op_char) + 6'd1, ERR_NONE, tok_start, 16'd2);
                            taken = 1'b1;
                        end else begin
                            emit(op_kind(op_char), ERR_NONE, tok_start, 16'd1);
                        end
                        mode = MODE_IDLE;
                    end
                    MODE_STR: begin
                        bump_len();
                        taken = 1'b1;
                        if (c == CH_QUOTE) begin
                            emit(K_STR, ERR_NONE, tok_start, tok_len);
                            mode = MODE_IDLE;
                        end
                    end
                    MODE_NUM: begin
                        if (is_dec(c)) begin
                            bump_len();
                            taken = 1'b1;
                        end else begin
                            emit(K_INT, ERR_NONE, tok_start, tok_len);
                            mode = MODE_IDLE;
                        end
                    end
                    MODE_IDENT: begin
                        if (is_word(c)) begin
                            if (tok_len < KW_BYTES) kw_buf[tok_len] = c;
                            bump_len();
                            taken = 1'b1;
                        end else begin
                            emit(word_kind(), ERR_NONE, tok_start, tok_len);
                            mode = MODE_IDLE;
                        end
                    end
                    default: ;
                endcase
                if (!taken) start_token(c, here);
                if (pos != POS_MAX) pos++;
            end
            if (expected_tokens.size() > prior_count) begin
                t = expected_tokens.pop_back();
                t.last = 1'b1;
                expected_tokens.push_back(t);
            end
        endfunction

        function void cmp_field(string name, logic [23:0] want, logic [23:0] got);
            if (want !== got) begin
                errors++;
                // cap the log; the count still decides the verdict
                if (errors <= 40)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_token(t_token got);
            t_token want;
            if (expected_tokens.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: token with none expected, actual kind %0d start %0d",
                             $time, got.kind, got.start);
                return;
            end
            want = expected_tokens.pop_front();
            cmp_field("token_kind",   24'(want.kind),  24'(got.kind));
            cmp_field("error_kind",   24'(want.err),   24'(got.err));
            cmp_field("token_start",  want.start,      got.start);
            cmp_field("token_length", 24'(want.len),   24'(got.len));
            cmp_field("line_number",  want.line,       got.line);
            cmp_field("last_of_item", 24'(want.last),  24'(got.last));
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tk_in_if  in_if();
    tk_out_if out_if();

    source_code_tokenizer_core #(
        .MAX_TOKEN_LENGTH(TOK_LEN_MAX),
        .KEYWORD_BYTES   (KW_BYTES)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    token_scoreboard sb;
    bit              tx_quiet;
    bit              long_hold_req;
    int              items_sent;
    int unsigned     cycles;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready)
            sb.check_token(t_token'{out_if.token_kind, out_if.error_kind,
                                    out_if.token_start, out_if.token_length,
                                    out_if.line_number, out_if.last_of_item});
    end

    function automatic int stall_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int tx_gap();
        if (tx_quiet || $urandom_range(0, 99) < 70) return 0;
        return stall_len();
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? 8'h20 : 8'(r);
    endfunction

    // string body: any byte but the quote and zero
    function automatic logic [7:0] rand_str_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        return (c == CH_QUOTE) ? CH_NL : c;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(logic [7:0] c, logic eoi);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid        <= 1'b1;
        in_if.char_byte    <= c;
        in_if.end_of_input <= eoi;
        do @(posedge clk); while (!in_if.ready);
        sb.scan_byte(c, eoi);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic send_fragment();
        string      w;
        logic [7:0] c;
        string      ops;
        ops = "(){}+-;,./*=!<>";
        case ($urandom_range(0, 9))
            0, 1: begin
                w = sb.kw_words[$urandom_range(0, KW_NUM - 1)];
                // whole keywords, and near misses of a keyword that must stay identifiers
                case ($urandom_range(0, 5))
                    0: begin
                        send_text(w);
                        send_byte(rand_word_char(), 1'b0);
                    end
                    1: send_text(w.substr(0, w.len() - 2));
                    2: begin
                        send_byte(w[0] - 8'h20, 1'b0);
                        send_text(w.substr(1, w.len() - 1));
                    end
                    default: send_text(w);
                endcase
            end
            2, 3: begin
                c = rand_word_char();
                if (c >= "0" && c <= "9") c = CH_UNDER;
                send_byte(c, 1'b0);
                repeat ($urandom_range(0, 8)) send_byte(rand_word_char(), 1'b0);
            end
            4: repeat ($urandom_range(1, 8)) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
            5: begin
                send_byte(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 10)) send_byte(rand_str_char(), 1'b0);
                send_byte(CH_QUOTE, 1'b0);
            end
            6, 7: begin
                c = ops[$urandom_range(0, ops.len() - 1)];
                send_byte(c, 1'b0);
                if ((c == "=" || c == "!" || c == "<" || c == ">") && $urandom_range(0, 1))
                    send_byte(CH_EQ, 1'b0);
            end
            8: repeat ($urandom_range(1, 4)) send_byte(rand_blank(), 1'b0);
            default: send_byte(8'($urandom_range(1, 255)), 1'b0);
        endcase
        if ($urandom_range(0, 1)) send_byte(rand_blank(), 1'b0);
    endtask

    task automatic random_run(int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
            send_fragment();
        end
        tx_quiet = 1'b0;
    endtask

    // output side: short and long stalls, quiet stretches, one long hold on request
    initial begin : rx_side
        int hold;
        int quiet_left;
        bit rx_quiet;
        hold       = 0;
        quiet_left = 0;
        rx_quiet   = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (quiet_left == 0) begin
                rx_quiet   = ($urandom_range(0, 3) == 0);
                quiet_left = 200;
            end
            quiet_left--;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else if (hold == 0 && !rx_quiet && $urandom_range(0, 99) < 25) begin
                hold = stall_len();
            end
            if (hold > 0) begin
                hold--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        sb                 = new();
        tx_quiet           = 1'b0;
        long_hold_req      = 1'b0;
        items_sent         = 0;
        cycles             = 0;
        rst_n              = 1'b0;
        in_if.valid        = 1'b0;
        in_if.char_byte    = 8'h00;
        in_if.end_of_input = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // keyword and identifiers closed by operators, two-byte operators,
        // high and low unknown bytes, a string holding a newline, number closed by newline
        send_text("while(a1!=b)<=>");
        send_byte(8'h80, 1'b0);
        send_text("\"q\n");
        send_byte(8'hFF, 1'b0);
        send_text("\"7\n");
        send_byte(8'h01, 1'b0);
        send_text("_");
        send_byte(8'h7F, 1'b0);

        // hold the output off while bytes keep coming so the input backs up
        long_hold_req = 1'b1;
        tx_quiet      = 1'b1;
        repeat (60) send_fragment();

        random_run(RANDOM_ITEMS / 2);
        random_run(RANDOM_ITEMS / 2);

        // end inside an open string, by zero byte or by the end flag
        send_text("\"ab\n");
        if ($urandom_range(0, 1)) send_byte(CH_NUL, 1'b0);
        else send_byte(8'($urandom_range(0, 255)), 1'b1);

        // drop everything after end of input
        repeat (4) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        in_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: source_code_tokenizer_core.f
design/tk_pkg.sv
design/tk_if.sv
design/tk_queue.sv
design/tk_front.sv
design/tk_back.sv
design/source_code_tokenizer_core.sv
tb/sv/tb_source_code_tokenizer_core.sv
